[rtl/ssvg_pkg.sv]
// Package: shared constants, types and trig helpers for the sphere strip vertex generator
`default_nettype none
package ssvg_pkg;

    localparam int MAX_SLICES_DEF = 31;
    localparam int TRIG_BITS_DEF  = 16;

    localparam int RADIUS_W = 15;
    localparam int SLICE_W  = 5;
    localparam int STACK_W  = 8;
    localparam int COORD_W  = 16;
    localparam int CFG_W    = 15;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_SLICES = 2'd1;
    localparam logic [IDX_W-1:0] REG_STACKS = 2'd2;

    localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

    // One band job as it travels from the front part to the back part
    typedef struct packed {
        logic [STACK_W-1:0] band;
        logic [SLICE_W-1:0] slices;
        logic [8:0]         den2;
    } t_job;

    // Factorial step divisor for Taylor term k (1..6) of sine (is_sin) or cosine
    function automatic logic [7:0] taylor_div(input logic [2:0] k, input logic is_sin);
        logic [7:0] kk;
        begin
            kk = {4'd0, k, 1'b0};
            if (is_sin) taylor_div = 8'(kk * (kk + 8'd1));
            else        taylor_div = 8'(kk * (kk - 8'd1));
        end
    endfunction

endpackage
`default_nettype wire

[rtl/ssvg_divider.sv]
// Module: restoring divider, one quotient bit per cycle, used for the phase steps
`default_nettype none
module ssvg_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic [63:0]      o_quot
);
    logic [63:0] r_num, n_num;
    logic [63:0] r_quot, n_quot;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_try;

    always_comb begin
        n_num  = r_num;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_try  = {r_rem[31:0], r_num[63]};
        if (r_busy) begin
            // shift in one numerator bit and subtract when it fits
            n_num = {r_num[62:0], 1'b0};
            if (w_try >= {1'b0, r_den}) begin
                n_rem  = w_try - {1'b0, r_den};
                n_quot = {r_quot[62:0], 1'b1};
            end else begin
                n_rem  = w_try;
                n_quot = {r_quot[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_busy = r_busy | i_start;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

[rtl/ssvg_front.sv]
// Module: front part, accepts band indices, clamps configuration and queues jobs
`default_nettype none
module ssvg_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [ssvg_pkg::STACK_W-1:0]   i_stack_index,
    input  wire logic [ssvg_pkg::SLICE_W-1:0]   i_slices_cfg,
    input  wire logic [ssvg_pkg::STACK_W-1:0]   i_stacks_cfg,
    output logic                                o_job_valid,
    output ssvg_pkg::t_job                      o_job,
    input  wire logic                           i_job_take
);
    import ssvg_pkg::*;

    localparam int DEPTH = 2;

    t_job        r_q [DEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic [SLICE_W-1:0] w_s;
    logic [STACK_W-1:0] w_t;
    logic        w_acc, w_push, w_pop;

    // raise counts below their minimums: 3 slices, 2 stacks
    always_comb begin
        w_s = i_slices_cfg;
        if (w_s < SLICE_W'(3)) w_s = SLICE_W'(3);
        w_t = i_stacks_cfg;
        if (w_t < STACK_W'(2)) w_t = STACK_W'(2);
    end

    assign o_stall = (r_cnt == 2'(DEPTH));
    assign w_acc   = i_valid && !o_stall;
    // drop bands out of range
    assign w_push  = w_acc && (i_stack_index < w_t);
    assign w_pop   = i_job_take && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{band: i_stack_index, slices: w_s, den2: {w_t, 1'b0}};
        end
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
endmodule
`default_nettype wire

[rtl/ssvg_back.sv]
// Module: back part, sequences phase, Taylor sine/cosine and vertex scaling per band
`default_nettype none
module ssvg_back #(
    parameter int TRIG_BITS  = ssvg_pkg::TRIG_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_job_valid,
    input  ssvg_pkg::t_job                      i_job,
    output logic                                o_job_take,
    input  wire logic [ssvg_pkg::RADIUS_W-1:0]  i_radius,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [ssvg_pkg::COORD_W-1:0] o_x_coord,
    output logic signed [ssvg_pkg::COORD_W-1:0] o_y_coord,
    output logic signed [ssvg_pkg::COORD_W-1:0] o_z_coord,
    output logic [ssvg_pkg::SLICE_W-1:0]        o_slice_position,
    output logic                                o_lower_ring,
    output logic                                o_last
);
    import ssvg_pkg::*;

    localparam int F  = TRIG_BITS - 1;
    localparam int SH = 30 - F;
    localparam int TW = TRIG_BITS + 1;   // signed trig width
    localparam int PW = 2 * TW + RADIUS_W + 2;

    // reciprocal scale: a Taylor numerator is below 2^33
    localparam logic [63:0] RCP_ONE = 64'd1 << 33;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PH    = 4'd1;
    localparam logic [3:0] ST_PHW   = 4'd2;
    localparam logic [3:0] ST_A     = 4'd3;
    localparam logic [3:0] ST_A2    = 4'd4;
    localparam logic [3:0] ST_TM    = 4'd5;
    localparam logic [3:0] ST_TD    = 4'd6;
    localparam logic [3:0] ST_TDW   = 4'd7;
    localparam logic [3:0] ST_RND   = 4'd8;
    localparam logic [3:0] ST_M1    = 4'd9;
    localparam logic [3:0] ST_M2    = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;
    localparam logic [3:0] ST_TDC   = 4'd12;

    logic [3:0]  r_st;
    t_job        r_job;
    logic [1:0]  r_which;   // 0 upper polar, 1 lower polar, 2 azimuth
    logic [SLICE_W-1:0] r_j;
    logic        r_ring;
    logic [31:0] r_phase;
    logic [31:0] r_a, r_a2;
    logic [31:0] r_ts, r_tc;
    logic signed [33:0] r_ss, r_cs;
    logic [2:0]  r_k;
    logic        r_tsel;    // 0 sine term, 1 cosine term
    logic [63:0] r_prod;
    logic [32:0] r_dn, r_qe, r_rm;
    logic [65:0] r_qm;
    logic signed [TW-1:0] r_sp [2];
    logic signed [TW-1:0] r_cp [2];
    logic signed [TW-1:0] r_st_s, r_ct_s;
    logic signed [2*TW-1:0] r_m1x, r_m1y;
    logic signed [PW-1:0] r_px, r_py, r_pz;
    logic signed [COORD_W-1:0] r_ox, r_oy, r_oz;
    logic [SLICE_W-1:0] r_oj;
    logic        r_oring, r_olast;

    logic        w_dstart;
    logic [63:0] w_dnum;
    logic [31:0] w_dden;
    logic        w_dbusy;
    logic [63:0] w_dq;
    logic [F:0]  w_s, w_c;
    logic signed [TW-1:0] w_sq, w_cq;
    logic        w_out_free;
    logic [7:0]  w_tdiv;
    logic [32:0] w_trcp;
    logic [32:0] w_tq;

    ssvg_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_busy  (w_dbusy),
        .o_quot  (w_dq)
    );

    // clamp and round a signed Q3.30 sum (34 bits) to F fraction bits
    function automatic logic [F:0] trig_rnd(input logic signed [33:0] sum);
        logic signed [33:0] v;
        logic [33:0]        r;
        begin
            v = sum;
            if (v < 0) v = '0;
            if (v > $signed({2'b0, ONE_Q30})) v = $signed({2'b0, ONE_Q30});
            r = (34'(v) + (34'd1 << (SH - 1))) >> SH;
            if (r > 34'((1 << F) - 1)) r = 34'((1 << F) - 1);
            trig_rnd = r[F:0];
        end
    endfunction

    // round magnitude of p / 2^sh half away from zero
    function automatic logic [COORD_W-1:0] scl(input logic signed [PW-1:0] p, input int sh);
        logic [PW-1:0] m;
        begin
            m = p[PW-1] ? PW'(-p) : PW'(p);
            m = (m + (PW'(1) << (sh - 1))) >> sh;
            if (p[PW-1]) m = PW'(-m);
            scl = m[COORD_W-1:0];
        end
    endfunction

    // floor(2^33 / d) for each factorial step divisor
    function automatic logic [32:0] taylor_rcp(input logic [7:0] d);
        begin
            case (d)
                8'd2:    taylor_rcp = 33'(RCP_ONE / 64'd2);
                8'd6:    taylor_rcp = 33'(RCP_ONE / 64'd6);
                8'd12:   taylor_rcp = 33'(RCP_ONE / 64'd12);
                8'd20:   taylor_rcp = 33'(RCP_ONE / 64'd20);
                8'd30:   taylor_rcp = 33'(RCP_ONE / 64'd30);
                8'd42:   taylor_rcp = 33'(RCP_ONE / 64'd42);
                8'd56:   taylor_rcp = 33'(RCP_ONE / 64'd56);
                8'd72:   taylor_rcp = 33'(RCP_ONE / 64'd72);
                8'd90:   taylor_rcp = 33'(RCP_ONE / 64'd90);
                8'd110:  taylor_rcp = 33'(RCP_ONE / 64'd110);
                8'd132:  taylor_rcp = 33'(RCP_ONE / 64'd132);
                8'd156:  taylor_rcp = 33'(RCP_ONE / 64'd156);
                default: taylor_rcp = '0;
            endcase
        end
    endfunction

    assign w_s = trig_rnd(r_ss);
    assign w_c = trig_rnd(r_cs);

    // Taylor step divisor, its reciprocal, and the corrected quotient
    assign w_tdiv = taylor_div(r_k, !r_tsel);
    assign w_trcp = taylor_rcp(w_tdiv);
    assign w_tq   = r_qe + 33'(r_rm >= 33'(w_tdiv));

    // quadrant fold
    always_comb begin
        case (r_phase[31:30])
            2'd0: begin w_sq = TW'($signed({1'b0, w_s}));  w_cq = TW'($signed({1'b0, w_c})); end
            2'd1: begin w_sq = TW'($signed({1'b0, w_c}));  w_cq = -TW'($signed({1'b0, w_s})); end
            2'd2: begin w_sq = -TW'($signed({1'b0, w_s})); w_cq = -TW'($signed({1'b0, w_c})); end
            default: begin w_sq = -TW'($signed({1'b0, w_c})); w_cq = TW'($signed({1'b0, w_s})); end
        endcase
    end

    // divider operands
    always_comb begin
        w_dstart = 1'b0;
        w_dnum   = '0;
        w_dden   = 32'd1;
        if (r_st == ST_PH) begin
            w_dstart = 1'b1;
            if (r_which == 2'd2) begin
                w_dnum = {27'd0, r_j, 32'd0} + 64'(r_job.slices >> 1);
                w_dden = 32'(r_job.slices);
            end else begin
                w_dnum = {24'd0, 8'(r_job.band + STACK_W'(r_which[0])), 32'd0}
                         + 64'(r_job.den2 >> 1);
                w_dden = 32'(r_job.den2);
            end
        end
    end

    assign w_out_free = !o_valid || !i_stall;
    assign o_job_take = (r_st == ST_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_st != ST_OUT) o_valid <= 1'b0;
            case (r_st)
                ST_IDLE: if (i_job_valid) begin
                    r_st    <= ST_PH;
                    r_which <= 2'd0;
                    r_j     <= '0;
                end
                ST_PH: r_st <= ST_PHW;
                ST_PHW: if (!w_dbusy) begin
                    // wrap to zero at the closing slice
                    if (r_which == 2'd2 && r_j == r_job.slices) r_phase <= '0;
                    else r_phase <= w_dq[31:0];
                    r_st <= ST_A;
                end
                ST_A: begin
                    r_prod <= 64'(r_phase[29:0]) * 64'(PI_HALF_Q30);
                    r_st   <= ST_A2;
                end
                ST_A2: begin
                    r_a  <= 32'(r_prod[63:30]);
                    r_st <= ST_TM;
                    r_k  <= 3'd0;
                end
                ST_TM: begin
                    if (r_k == 3'd0) begin
                        r_prod <= 64'(r_a) * 64'(r_a);
                        r_ts   <= r_a;
                        r_tc   <= ONE_Q30;
                        r_ss   <= 34'(r_a);
                        r_cs   <= 34'(ONE_Q30);
                        r_k    <= 3'd1;
                        r_tsel <= 1'b0;
                        r_st   <= ST_TM;
                        r_a2   <= 32'((64'(r_a) * 64'(r_a)) >> 30);
                    end else begin
                        r_prod <= 64'(r_tsel ? r_tc : r_ts) * 64'(r_a2);
                        r_st   <= ST_TD;
                    end
                end
                // estimate the quotient by reciprocal multiplication
                ST_TD: begin
                    r_dn <= r_prod[62:30];
                    r_qm <= 66'(r_prod[62:30]) * 66'(w_trcp);
                    r_st <= ST_TDW;
                end
                // estimate is the quotient or one below it
                ST_TDW: begin
                    r_qe <= r_qm[65:33];
                    r_rm <= r_dn - 33'(r_qm[65:33] * 33'(w_tdiv));
                    r_st <= ST_TDC;
                end
                ST_TDC: begin
                    if (r_tsel) begin
                        r_tc <= w_tq[31:0];
                        r_cs <= r_k[0] ? r_cs - 34'(w_tq[31:0]) : r_cs + 34'(w_tq[31:0]);
                    end else begin
                        r_ts <= w_tq[31:0];
                        r_ss <= r_k[0] ? r_ss - 34'(w_tq[31:0]) : r_ss + 34'(w_tq[31:0]);
                    end
                    r_tsel <= ~r_tsel;
                    if (r_tsel) begin
                        if (r_k == 3'd6) r_st <= ST_RND;
                        else begin r_k <= r_k + 3'd1; r_st <= ST_TM; end
                    end else r_st <= ST_TM;
                end
                ST_RND: begin
                    if (r_which == 2'd2) begin
                        r_st_s <= w_sq;
                        r_ct_s <= w_cq;
                        r_ring <= 1'b0;
                        r_st   <= ST_M1;
                    end else begin
                        r_sp[r_which[0]] <= w_sq;
                        r_cp[r_which[0]] <= w_cq;
                        r_which <= r_which + 2'd1;
                        r_st    <= ST_PH;
                    end
                end
                ST_M1: begin
                    r_m1x <= -(r_st_s * r_sp[r_ring]);
                    r_m1y <= r_ct_s * r_sp[r_ring];
                    r_st  <= ST_M2;
                end
                ST_M2: begin
                    r_px <= PW'(r_m1x) * $signed({1'b0, i_radius});
                    r_py <= PW'(r_m1y) * $signed({1'b0, i_radius});
                    r_pz <= PW'(r_cp[r_ring]) * $signed({1'b0, i_radius});
                    r_st <= ST_OUT;
                end
                ST_OUT: if (w_out_free) begin
                    o_valid <= 1'b1;
                    r_ox    <= scl(r_px, 2 * F);
                    r_oy    <= scl(r_py, 2 * F);
                    r_oz    <= scl(r_pz, F);
                    r_oj    <= r_j;
                    r_oring <= r_ring;
                    r_olast <= r_ring && (r_j == r_job.slices);
                    // advance ring, then slice
                    if (!r_ring) begin
                        r_ring <= 1'b1;
                        r_st   <= ST_M1;
                    end else if (r_j == r_job.slices) begin
                        r_st <= ST_IDLE;
                    end else begin
                        r_j  <= r_j + SLICE_W'(1);
                        r_st <= ST_PH;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) r_job <= i_job;
    end

    assign o_x_coord        = r_ox;
    assign o_y_coord        = r_oy;
    assign o_z_coord        = r_oz;
    assign o_slice_position = r_oj;
    assign o_lower_ring     = r_oring;
    assign o_last           = r_olast;
endmodule
`default_nettype wire

[rtl/sphere_strip_vertex_gen_top.sv]
// Top level: sphere quad-strip vertex generator
//
// Input channel: i_valid/o_stall carry one band index per beat. Bands at or
// above the (clamped) stack count are dropped with no output.
// Output channel: o_valid/i_stall carry one vertex per beat, 2*(S+1) per
// band, upper then lower point for each slice 0..S, o_last on the final one.
// Config: i_cfg_we/i_cfg_index/i_cfg_data write radius, slice and stack
// counts; write only while the block is idle.
// Sequence: each angle computes its phase on the serial divider, sets up
// the series, runs twelve Taylor terms (reciprocal multiply) and rounds.
// A band computes two polar angles and S+1 azimuth angles, and these
// angles dominate its time when the output does not stall.
// A two-entry job queue lets the front take bands while the back works.
// Reset clears the queue, the sequencer and output valid; registers return
// to radius 256, 16 slices, 16 stacks. A stalled output holds its vertex
// and the sequencer waits.
`default_nettype none
module sphere_strip_vertex_gen_top #(
    parameter int MAX_SLICES = ssvg_pkg::MAX_SLICES_DEF,
    parameter int TRIG_BITS  = ssvg_pkg::TRIG_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ssvg_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [ssvg_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [ssvg_pkg::STACK_W-1:0]   i_stack_index,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [ssvg_pkg::COORD_W-1:0] o_x_coord,
    output logic signed [ssvg_pkg::COORD_W-1:0] o_y_coord,
    output logic signed [ssvg_pkg::COORD_W-1:0] o_z_coord,
    output logic [ssvg_pkg::SLICE_W-1:0]        o_slice_position,
    output logic                                o_lower_ring,
    output logic                                o_last
);
    import ssvg_pkg::*;

    logic [RADIUS_W-1:0] r_radius;
    logic [SLICE_W-1:0]  r_slices;
    logic [STACK_W-1:0]  r_stacks;
    logic [SLICE_W-1:0]  w_slices;
    logic                w_job_valid, w_job_take;
    t_job                w_job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_W'(256);
            r_slices <= SLICE_W'(16);
            r_stacks <= STACK_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RADIUS: r_radius <= i_cfg_data[RADIUS_W-1:0];
                REG_SLICES: r_slices <= i_cfg_data[SLICE_W-1:0];
                REG_STACKS: r_stacks <= i_cfg_data[STACK_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_slices = (32'(r_slices) > 32'(MAX_SLICES)) ? SLICE_W'(MAX_SLICES) : r_slices;

    ssvg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_stack_index (i_stack_index),
        .i_slices_cfg  (w_slices),
        .i_stacks_cfg  (r_stacks),
        .o_job_valid   (w_job_valid),
        .o_job         (w_job),
        .i_job_take    (w_job_take)
    );

    ssvg_back #(
        .TRIG_BITS  (TRIG_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (w_job_valid),
        .i_job            (w_job),
        .o_job_take       (w_job_take),
        .i_radius         (r_radius),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_x_coord        (o_x_coord),
        .o_y_coord        (o_y_coord),
        .o_z_coord        (o_z_coord),
        .o_slice_position (o_slice_position),
        .o_lower_ring     (o_lower_ring),
        .o_last           (o_last)
    );
endmodule
`default_nettype wire

[rtl/ssvg_checker.sv]
// Checker: port-level properties of the vertex generator, bound to the top level
`default_nettype none
module ssvg_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [4:0] o_slice_position,
    input wire logic       o_lower_ring,
    input wire logic       o_last
);
    // a stalled beat holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_slice_position))
        else $error("stalled beat changed");

    // last only on a lower point
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_lower_ring)
        else $error("last on upper point");

    // an accepted upper point at a nonzero slice is not directly followed by a lower point at slice 0
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_lower_ring |=> !(o_valid && o_slice_position == 5'd0
            && o_lower_ring && $past(o_slice_position) != 5'd0))
        else $error("ring order broken");
endmodule

bind sphere_strip_vertex_gen_top ssvg_checker u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_slice_position (o_slice_position),
    .o_lower_ring     (o_lower_ring),
    .o_last           (o_last)
);
`default_nettype wire
